[hw/rtl/dsfp_pkg.sv]
// Shared types and constants of the dust sensor frame parser.
// Used by every module of the block; it depends on nothing else.

package dsfp_pkg;

    // Sync pair that opens each sensor frame.
    localparam logic [7:0] SYNC_FIRST  = 8'hFF;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CONC_W = 16;

    typedef logic [BYTE_W-1:0] t_byte;

    // One parsed frame as it leaves the block.
    typedef struct packed {
        logic [CONC_W-1:0] concentration;
        logic              checksum_ok;
    } t_result;

endpackage

[hw/rtl/dsfp_in_reg.sv]
// Input register of the dust sensor frame parser: holds one received byte
// until the parser takes it. Depends on dsfp_pkg.

module dsfp_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tvalid,
    output logic            o_tready,
    input  dsfp_pkg::t_byte i_tdata,
    input  logic            i_consume,
    output logic            o_valid,
    output dsfp_pkg::t_byte o_byte
);

    logic            r_valid;
    dsfp_pkg::t_byte r_byte;

    // The register takes a new beat when empty or when its byte leaves now.
    assign o_tready = !r_valid || i_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_tvalid && o_tready) begin
            r_valid <= 1'b1;
        end else if (i_consume) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_tvalid && o_tready) begin
            r_byte <= i_tdata;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

[hw/rtl/dsfp_parse.sv]
// Frame state machine of the dust sensor frame parser: sync hunt, data
// capture and additive checksum. Depends on dsfp_pkg.

module dsfp_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  dsfp_pkg::t_byte   i_byte,
    input  logic              i_out_free,
    output logic              o_consume,
    output logic              o_res_valid,
    output dsfp_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_D0,
        PH_D1,
        PH_D2,
        PH_D3,
        PH_D4,
        PH_D5
    } t_phase;

    t_phase          r_phase, n_phase;
    dsfp_pkg::t_byte r_high, n_high;
    dsfp_pkg::t_byte r_low, n_low;
    dsfp_pkg::t_byte r_sum, n_sum;
    logic            r_match, n_match;

    // Only the last data byte needs room in the result register.
    assign o_consume   = i_valid && ((r_phase != PH_D5) || i_out_free);
    assign o_res_valid = o_consume && (r_phase == PH_D5);
    assign o_res.concentration = {r_high, r_low};
    assign o_res.checksum_ok   = r_match;

    // Next state for the byte at hand.
    always_comb begin
        n_phase = r_phase;
        n_high  = r_high;
        n_low   = r_low;
        n_sum   = r_sum;
        n_match = r_match;
        case (r_phase)
            PH_HUNT: begin
                n_phase = (i_byte == dsfp_pkg::SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
            end
            PH_SYNC2: begin
                // A broken pair drops the byte, even a repeated 0xFF.
                n_phase = (i_byte == dsfp_pkg::SYNC_SECOND) ? PH_D0 : PH_HUNT;
            end
            PH_D0: begin
                n_high  = i_byte;
                n_sum   = i_byte;
                n_phase = PH_D1;
            end
            PH_D1: begin
                n_low   = i_byte;
                n_sum   = r_sum + i_byte;
                n_phase = PH_D2;
            end
            PH_D2: begin
                n_sum   = r_sum + i_byte;
                n_phase = PH_D3;
            end
            PH_D3: begin
                n_sum   = r_sum + i_byte;
                n_phase = PH_D4;
            end
            PH_D4: begin
                n_match = (r_sum == i_byte);
                n_phase = PH_D5;
            end
            PH_D5: begin
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    // State and captured frame fields.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_high  <= '0;
            r_low   <= '0;
            r_sum   <= '0;
            r_match <= 1'b0;
        end else if (o_consume) begin
            r_phase <= n_phase;
            r_high  <= n_high;
            r_low   <= n_low;
            r_sum   <= n_sum;
            r_match <= n_match;
        end
    end

`ifndef SYNTHESIS
    // A result is produced only when the result register is empty or its beat leaves now.
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_out_free)
        else $error("result produced without room in output register");

    // After the last data byte the parser hunts for sync again.
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_phase == PH_HUNT))
        else $error("parser did not return to sync hunt after a frame");

    // A non-sync byte during the hunt leaves the parser hunting.
    a_hunt_stay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_consume && (r_phase == PH_HUNT) && (i_byte != dsfp_pkg::SYNC_FIRST))
        |=> (r_phase == PH_HUNT))
        else $error("parser left the hunt without a sync byte");
`endif

endmodule

[hw/rtl/dsfp_out_reg.sv]
// Result register of the dust sensor frame parser: holds one parsed frame
// until the downstream side takes the beat. Depends on dsfp_pkg.

module dsfp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  dsfp_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_tvalid,
    input  logic              i_tready,
    output dsfp_pkg::t_result o_res
);

    logic              r_valid;
    dsfp_pkg::t_result r_res;

    // Room for a new result when empty or when the held beat leaves now.
    assign o_free = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_tvalid = r_valid;
    assign o_res    = r_res;

endmodule

[hw/rtl/dust_sensor_frame_parser_core.sv]
// Top level of the dust sensor frame parser.
// Instantiates dsfp_in_reg, dsfp_parse and dsfp_out_reg; uses dsfp_pkg.

// The block takes one received sensor byte per beat, hunts for the sync pair
// 0xFF then 0xAA, collects six data bytes and emits one beat per frame: the
// concentration (first data byte high, second low) and a flag that is set
// when the first four data bytes summed mod 256 equal the fifth. A byte
// passes through the input register, then through the frame state machine
// into the result register. One byte is accepted every cycle; only a
// stalled result beat at the end of a frame holds up the input.

module dust_sensor_frame_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] concentration
    output logic        o_m_tuser    // [0] checksum_ok
);

    logic              w_in_valid;
    dsfp_pkg::t_byte   w_in_byte;
    logic              w_consume;
    logic              w_out_free;
    logic              w_res_valid;
    dsfp_pkg::t_result w_res;
    dsfp_pkg::t_result w_out_res;

    // Input register.
    dsfp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (i_s_tvalid),
        .o_tready  (o_s_tready),
        .i_tdata   (i_s_tdata),
        .i_consume (w_consume),
        .o_valid   (w_in_valid),
        .o_byte    (w_in_byte)
    );

    // Frame state machine.
    dsfp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_in_valid),
        .i_byte      (w_in_byte),
        .i_out_free  (w_out_free),
        .o_consume   (w_consume),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Result register.
    dsfp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_res_valid),
        .i_res    (w_res),
        .o_free   (w_out_free),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_res    (w_out_res)
    );

    assign o_m_tdata = w_out_res.concentration;
    assign o_m_tuser = w_out_res.checksum_ok;

endmodule

[tb/dsfp_frame_checker.sv]
`timescale 1ns / 100ps
// Frame checker for the dust sensor frame parser testbench.
// Watches both stream channels, predicts parsed frames and compares them;
// depends on dsfp_pkg.

module dsfp_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [15:0] concentration
    input  logic        i_m_tuser,   // [0] checksum_ok
    output int          o_error_count,
    output int          o_frames_pending,
    output int          o_frames_checked
);

    // Where the parser stands within a sensor frame.
    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        TAKE_HIGH,
        TAKE_LOW,
        TAKE_SUM2,
        TAKE_SUM3,
        TAKE_CHECK,
        TAKE_LAST
    } t_frame_phase;

    t_frame_phase      frame_phase;
    dsfp_pkg::t_byte   conc_high;
    dsfp_pkg::t_byte   conc_low;
    dsfp_pkg::t_byte   byte_sum;
    logic              sum_matched;
    dsfp_pkg::t_result expected_frames[$];

    // One line per mismatch, and one more failure on the count.
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        o_error_count++;
    endtask

    // Advance the frame parse by one received byte; a finished frame is queued.
    task automatic parse_rx_byte(input dsfp_pkg::t_byte rx);
        case (frame_phase)
            HUNT_FIRST: begin
                frame_phase = (rx == dsfp_pkg::SYNC_FIRST) ? HUNT_SECOND : HUNT_FIRST;
            end
            HUNT_SECOND: begin
                // A wrong second sync byte is dropped, even a repeated 0xFF.
                frame_phase = (rx == dsfp_pkg::SYNC_SECOND) ? TAKE_HIGH : HUNT_FIRST;
            end
            TAKE_HIGH: begin
                conc_high   = rx;
                byte_sum    = rx;
                frame_phase = TAKE_LOW;
            end
            TAKE_LOW: begin
                conc_low    = rx;
                byte_sum    = byte_sum + rx;
                frame_phase = TAKE_SUM2;
            end
            TAKE_SUM2: begin
                byte_sum    = byte_sum + rx;
                frame_phase = TAKE_SUM3;
            end
            TAKE_SUM3: begin
                byte_sum    = byte_sum + rx;
                frame_phase = TAKE_CHECK;
            end
            TAKE_CHECK: begin
                sum_matched = (byte_sum == rx);
                frame_phase = TAKE_LAST;
            end
            default: begin
                // The last data byte carries nothing but closes the frame.
                expected_frames.push_back(dsfp_pkg::t_result'{
                    concentration: {conc_high, conc_low},
                    checksum_ok:   sum_matched
                });
                frame_phase = HUNT_FIRST;
            end
        endcase
    endtask

    // Both channels are sampled at the rising edge; a result beat always
    // belongs to a byte accepted at an earlier edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_phase = HUNT_FIRST;
            conc_high   = '0;
            conc_low    = '0;
            byte_sum    = '0;
            sum_matched = 1'b0;
            expected_frames.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_frames.size() == 0) begin
                    report_mismatch($sformatf("result beat %h/%b with no frame pending",
                                              i_m_tdata, i_m_tuser));
                end else begin
                    dsfp_pkg::t_result exp_frame;
                    exp_frame = expected_frames.pop_front();
                    if (i_m_tdata !== exp_frame.concentration)
                        report_mismatch($sformatf("concentration %h, expected %h",
                                                  i_m_tdata, exp_frame.concentration));
                    if (i_m_tuser !== exp_frame.checksum_ok)
                        report_mismatch($sformatf("checksum_ok %b, expected %b for %h",
                                                  i_m_tuser, exp_frame.checksum_ok,
                                                  exp_frame.concentration));
                    o_frames_checked++;
                end
            end
            if (i_s_tvalid && i_s_tready)
                parse_rx_byte(i_s_tdata);
        end
        o_frames_pending = expected_frames.size();
    end

endmodule

[tb/dust_sensor_frame_parser_core_tb.sv]
`timescale 1ns / 100ps
// Top of the dust sensor frame parser testbench: clock, reset, byte stimulus
// and verdict. Needs dust_sensor_frame_parser_core, dsfp_frame_checker and dsfp_pkg.

module dust_sensor_frame_parser_core_tb;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int BYTES_PER_RUN = 500;

    // Directed opening: an all-zero frame, a sync broken by a second 0xFF,
    // an all-ones frame whose checksum wraps, and a frame whose data opens with
    // both sync bytes and has a bad checksum.
    localparam dsfp_pkg::t_byte DIRECTED_BYTES [27] = '{
        8'hFF, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hFF, 8'hFF, 8'hAA,
        8'hFF, 8'hAA, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFC, 8'hFF,
        8'hFF, 8'hAA, 8'hAA, 8'hFF, 8'h12, 8'h34, 8'h11, 8'h55
    };

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tready  = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;
    logic        o_m_tuser;

    int error_count;
    int frames_pending;
    int frames_checked;
    int cycle_count    = 0;
    int bytes_sent     = 0;
    int src_idle_pct   = 38;
    int sink_idle_pct  = 56;

    dust_sensor_frame_parser_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    dsfp_frame_checker frame_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (o_s_tready),
        .i_s_tdata        (s_tdata),
        .i_m_tvalid       (o_m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (o_m_tdata),
        .i_m_tuser        (o_m_tuser),
        .o_error_count    (error_count),
        .o_frames_pending (frames_pending),
        .o_frames_checked (frames_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Cycle counter and watchdog.
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("dust_sensor_frame_parser_core regression: fail");
        $finish;
    end

    // Result side: ready drops at random at the configured rate.
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Offer one byte, idling first at random, and hold it until accepted.
    task automatic send_byte(input dsfp_pkg::t_byte rx);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= dsfp_pkg::t_byte'($urandom);
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do @(posedge i_clk); while (!o_s_tready);
        bytes_sent++;
    endtask

    // Data bytes lean toward the extremes and the sync values.
    function automatic dsfp_pkg::t_byte pick_data_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return dsfp_pkg::SYNC_FIRST;
            2:       return dsfp_pkg::SYNC_SECOND;
            default: return dsfp_pkg::t_byte'($urandom);
        endcase
    endfunction

    // Mostly whole frames with random content, the rest broken syncs and noise.
    task automatic send_random_burst();
        int              kind;
        dsfp_pkg::t_byte data [6];
        dsfp_pkg::t_byte sum;
        dsfp_pkg::t_byte odd;
        kind = $urandom_range(99);
        if (kind < 75) begin
            sum = '0;
            foreach (data[i]) data[i] = pick_data_byte();
            for (int i = 0; i < 4; i++) sum = sum + data[i];
            if ($urandom_range(1)) data[4] = sum;
            send_byte(dsfp_pkg::SYNC_FIRST);
            send_byte(dsfp_pkg::SYNC_SECOND);
            foreach (data[i]) send_byte(data[i]);
        end else if (kind < 87) begin
            odd = pick_data_byte();
            if (odd == dsfp_pkg::SYNC_SECOND) odd = dsfp_pkg::SYNC_FIRST;
            send_byte(dsfp_pkg::SYNC_FIRST);
            send_byte(odd);
        end else begin
            repeat ($urandom_range(4, 1)) send_byte(pick_data_byte());
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i]);

        // Receiver-heavy idling, then sender-heavy, then none at all.
        while (bytes_sent < BYTES_PER_RUN) send_random_burst();
        src_idle_pct  = 56;
        sink_idle_pct = 38;
        while (bytes_sent < 2 * BYTES_PER_RUN) send_random_burst();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        while (bytes_sent < 3 * BYTES_PER_RUN) send_random_burst();

        @(negedge i_clk);
        s_tvalid <= 1'b0;

        // Drain the frames still in flight, then allow for the pipeline.
        while (frames_pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d sensor bytes and checked %0d parsed frames,", bytes_sent,
                 frames_checked);
        $display("across sender-idle, receiver-idle and back-to-back phases.");
        if (error_count == 0) begin
            $display("dust_sensor_frame_parser_core regression: pass");
        end else begin
            $display("%0d mismatches", error_count);
            $display("dust_sensor_frame_parser_core regression: fail");
        end
        $finish;
    end

endmodule
